// File: src/twhbl_pkg.sv
package twhbl_pkg;

  localparam logic [1:0] LINE_MASK = 2'h3;
  localparam logic [7:0] TOP_BIT = 8'h80;
  localparam logic [15:0] TIMEOUT_RST = 16'd4096;

  localparam logic [1:0] KIND_TICK = 2'd0;
  localparam logic [1:0] KIND_SEND = 2'd1;
  localparam logic [1:0] KIND_RECV = 2'd2;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_TIMEOUT = 2'd1;
  localparam logic [1:0] ERR_LINK = 2'd2;
  localparam logic [1:0] ERR_BUSY = 2'd3;

  localparam logic [2:0] LAST_BIT = 3'd7;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'b001,
    MODE_SEND = 3'b010,
    MODE_RECV = 3'b100
  } mode_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] send_byte;
    logic [1:0] partner_pull;
  } in_t;

  typedef struct packed {
    logic [1:0] drive_out;
    logic       busy_res;
    logic       done_res;
    logic [1:0] error_code;
    logic [7:0] received_byte;
  } out_t;

  typedef struct packed {
    mode_t       mode;
    logic        phase;
    logic [2:0]  bit_index;
    logic [7:0]  shift_data;
    logic [15:0] wait_count;
    logic [1:0]  own_drive;
  } st_t;

endpackage

// File: src/twhbl_step.sv
module twhbl_step (
  input  twhbl_pkg::st_t  st,
  input  twhbl_pkg::in_t  din,
  input  logic [15:0]     timeout_ticks,
  output twhbl_pkg::st_t  st_nxt,
  output twhbl_pkg::out_t res
);

  logic        busy;
  logic [1:0]  high;
  logic [15:0] wait_inc;
  logic        tmo;
  logic [1:0]  err;
  logic        done;
  logic [7:0]  rx;

  assign busy     = (st.mode == twhbl_pkg::MODE_SEND) || (st.mode == twhbl_pkg::MODE_RECV);
  assign high     = ~(st.own_drive | din.partner_pull) & twhbl_pkg::LINE_MASK;
  assign wait_inc = st.wait_count + 16'd1;
  assign tmo      = (wait_inc >= timeout_ticks) || (wait_inc == 16'd0);

  always_comb begin
    st_nxt = st;
    err    = twhbl_pkg::ERR_NONE;
    done   = 1'b0;
    rx     = 8'd0;
    if (din.kind == twhbl_pkg::KIND_SEND || din.kind == twhbl_pkg::KIND_RECV) begin
      if (busy) begin
        err = twhbl_pkg::ERR_BUSY;
      end else if (din.kind == twhbl_pkg::KIND_SEND) begin
        st_nxt.mode       = twhbl_pkg::MODE_SEND;
        st_nxt.phase      = 1'b0;
        st_nxt.bit_index  = 3'd0;
        st_nxt.wait_count = 16'd0;
        st_nxt.shift_data = din.send_byte;
        st_nxt.own_drive  = din.send_byte[0] ? 2'd2 : 2'd1;
      end else begin
        st_nxt.mode       = twhbl_pkg::MODE_RECV;
        st_nxt.phase      = 1'b0;
        st_nxt.bit_index  = 3'd0;
        st_nxt.wait_count = 16'd0;
        st_nxt.shift_data = 8'd0;
        st_nxt.own_drive  = 2'd0;
      end
    end else if (busy) begin
      unique case (st.mode)
        twhbl_pkg::MODE_SEND: begin
          if (!st.phase) begin
            if (high != 2'd0) begin
              st_nxt.wait_count = wait_inc;
              if (tmo) err = twhbl_pkg::ERR_TIMEOUT;
            end else begin
              st_nxt.own_drive  = 2'd0;
              st_nxt.phase      = 1'b1;
              st_nxt.wait_count = 16'd0;
            end
          end else begin
            if (high != twhbl_pkg::LINE_MASK) begin
              st_nxt.wait_count = wait_inc;
              if (tmo) err = twhbl_pkg::ERR_TIMEOUT;
            end else begin
              st_nxt.wait_count = 16'd0;
              st_nxt.shift_data = {1'b0, st.shift_data[7:1]};
              if (st.bit_index == twhbl_pkg::LAST_BIT) begin
                done             = 1'b1;
                st_nxt.mode      = twhbl_pkg::MODE_IDLE;
                st_nxt.phase     = 1'b0;
                st_nxt.bit_index = 3'd0;
                st_nxt.own_drive = 2'd0;
              end else begin
                st_nxt.bit_index = st.bit_index + 3'd1;
                st_nxt.phase     = 1'b0;
                st_nxt.own_drive = st.shift_data[1] ? 2'd2 : 2'd1;
              end
            end
          end
        end
        twhbl_pkg::MODE_RECV: begin
          if (!st.phase) begin
            if (high == twhbl_pkg::LINE_MASK) begin
              st_nxt.wait_count = wait_inc;
              if (tmo) err = twhbl_pkg::ERR_TIMEOUT;
            end else if (high == 2'd0) begin
              err = twhbl_pkg::ERR_LINK;
            end else begin
              st_nxt.own_drive  = high;
              st_nxt.shift_data = {1'b0, st.shift_data[7:1]} |
                                  ((high == 2'd1) ? twhbl_pkg::TOP_BIT : 8'd0);
              st_nxt.phase      = 1'b1;
              st_nxt.wait_count = 16'd0;
            end
          end else begin
            if (high == 2'd0) begin
              st_nxt.wait_count = wait_inc;
              if (tmo) err = twhbl_pkg::ERR_TIMEOUT;
            end else begin
              st_nxt.own_drive  = 2'd0;
              st_nxt.wait_count = 16'd0;
              if (st.bit_index == twhbl_pkg::LAST_BIT) begin
                done             = 1'b1;
                rx               = st.shift_data;
                st_nxt.mode      = twhbl_pkg::MODE_IDLE;
                st_nxt.phase     = 1'b0;
                st_nxt.bit_index = 3'd0;
              end else begin
                st_nxt.bit_index = st.bit_index + 3'd1;
                st_nxt.phase     = 1'b0;
              end
            end
          end
        end
        default: begin
        end
      endcase
      if (err != twhbl_pkg::ERR_NONE) begin
        st_nxt.mode       = twhbl_pkg::MODE_IDLE;
        st_nxt.phase      = 1'b0;
        st_nxt.bit_index  = 3'd0;
        st_nxt.wait_count = 16'd0;
        st_nxt.own_drive  = 2'd0;
      end
    end else begin
      st_nxt.mode       = twhbl_pkg::MODE_IDLE;
      st_nxt.phase      = 1'b0;
      st_nxt.bit_index  = 3'd0;
      st_nxt.wait_count = 16'd0;
      st_nxt.own_drive  = 2'd0;
    end
  end

  always_comb begin
    res.drive_out     = st_nxt.own_drive;
    res.busy_res      = (st_nxt.mode == twhbl_pkg::MODE_SEND) ||
                        (st_nxt.mode == twhbl_pkg::MODE_RECV);
    res.done_res      = done;
    res.error_code    = err;
    res.received_byte = rx;
  end

endmodule

// File: src/two_wire_handshake_byte_link_core.sv
// Byte transceiver for a two-wire wired-AND handshake link. Each input beat is one sampling
// tick carrying the partner drive and an optional start-send or start-receive request; each
// tick yields exactly one result beat with the own drive, busy, done, error and received byte.
// Throughput is one beat per clock while results are accepted; a taken input goes to the input
// register, then through one pass of next-state logic into the result register, and stalls on
// the result side back up through the input register without losing beats. timeout_ticks is
// written through the cfg port and should only change while no transfer is running.
module two_wire_handshake_byte_link_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  twhbl_pkg::in_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output twhbl_pkg::out_t out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [15:0]     cfg_data
);

  twhbl_pkg::in_t  in_r;
  logic            in_vld_r;
  twhbl_pkg::st_t  st_r;
  twhbl_pkg::st_t  st_nxt;
  twhbl_pkg::out_t out_r;
  twhbl_pkg::out_t res_nxt;
  logic            out_vld_r;
  logic [15:0]     timeout_r;
  logic            advance;

  assign advance   = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !in_vld_r || advance;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  twhbl_step u_step (
    .st            (st_r),
    .din           (in_r),
    .timeout_ticks (timeout_r),
    .st_nxt        (st_nxt),
    .res           (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= twhbl_pkg::TIMEOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      timeout_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode       <= twhbl_pkg::MODE_IDLE;
      st_r.phase      <= 1'b0;
      st_r.bit_index  <= 3'd0;
      st_r.shift_data <= 8'd0;
      st_r.wait_count <= 16'd0;
      st_r.own_drive  <= 2'd0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= res_nxt;
    end
  end

  a_done_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_r.done_res |-> out_r.error_code == twhbl_pkg::ERR_NONE)
    else $error("done and error in the same beat");

  a_idle_released: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_r.busy_res |-> out_r.drive_out == 2'd0)
    else $error("lines driven while not busy");

  a_rx_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_r.received_byte != 8'd0 |-> out_r.done_res)
    else $error("received byte without done");

  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.mode == twhbl_pkg::MODE_IDLE |-> st_r.wait_count == 16'd0 && st_r.own_drive == 2'd0)
    else $error("idle state not cleared");

  a_advance_loads: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_vld_r)
    else $error("result beat lost");

endmodule
